[rtl/core/drd_pkg.sv]
`default_nettype none

package drd_pkg;

  // field widths
  localparam int VALUE_W     = 32;
  localparam int EDGE_W      = 30;
  localparam int CONF_W      = 17;
  localparam int CLASS_W     = 7;
  localparam int COUNT_W     = 16;
  localparam int SCALE_W     = 31;
  localparam int PAD_W       = 27;
  localparam int SIZE_W      = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;

  // row layout: four box fields, objectness, then class scores
  localparam int BOX_FIELDS      = 4;
  localparam int ROW_HEAD        = 5;
  localparam int DEF_MAX_CLASSES = 128;

  // queue depths
  localparam int JOB_QUEUE_DEPTH    = 4;
  localparam int RESULT_QUEUE_DEPTH = 2;

  // confidence saturation point (1.0 in Q16.16)
  localparam logic [CONF_W-1:0] CONF_MAX = 17'd65536;

  // register reset values
  localparam logic [CONF_W-1:0]  RST_SCORE_FLOOR = 17'd16384;
  localparam logic               RST_OBJ_ENABLE  = 1'b1;
  localparam logic [COUNT_W-1:0] RST_BOX_BUDGET  = 16'd1000;
  localparam logic [SCALE_W-1:0] RST_INV_SCALE   = 31'd65536;
  localparam logic [PAD_W-1:0]   RST_PAD         = 27'd0;
  localparam logic [SIZE_W-1:0]  RST_IMAGE_SIZE  = 14'd640;

  // result status codes
  localparam logic STATUS_KEPT   = 1'b0;
  localparam logic STATUS_BUDGET = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCORE_FLOOR  = 3'd0,
    REG_OBJ_ENABLE   = 3'd1,
    REG_BOX_BUDGET   = 3'd2,
    REG_INV_SCALE    = 3'd3,
    REG_PAD_X        = 3'd4,
    REG_PAD_Y        = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [CONF_W-1:0]  score_floor;
    logic               obj_enable;
    logic [COUNT_W-1:0] box_budget;
    logic [SCALE_W-1:0] inv_scale;
    logic [PAD_W-1:0]   pad_x;
    logic [PAD_W-1:0]   pad_y;
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
  } cfg_t;

  // one finished row (or frame mark) handed from front to back
  typedef struct packed {
    logic                      eval;
    logic                      eof;
    logic signed [VALUE_W-1:0] cx;
    logic signed [VALUE_W-1:0] cy;
    logic signed [VALUE_W-1:0] w;
    logic signed [VALUE_W-1:0] h;
    logic signed [VALUE_W-1:0] objectness;
    logic signed [VALUE_W-1:0] best_score;
    logic [CLASS_W-1:0]        top_class;
  } job_t;

  typedef struct packed {
    logic              status;
    logic [EDGE_W-1:0] box_x;
    logic [EDGE_W-1:0] box_y;
    logic [EDGE_W-1:0] box_width;
    logic [EDGE_W-1:0] box_height;
    logic [CLASS_W-1:0] class_num;
    logic [CONF_W-1:0] confidence;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCORE,
    BK_CHECK,
    BK_MAP,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

[rtl/core/detection_row_decoder_core.sv]
`default_nettype none

// Detection row decoder. Detector output rows stream in one signed Q16.16 word
// per cycle (centre x, centre y, width, height, objectness, class scores, the
// last class score flagged by end_of_row); kept boxes and budget errors come
// out of a result queue in row order. The front end takes one word every cycle
// while full is low and hands each finished row to a 4-entry row queue; the
// back end handles a row that passes the threshold and fits the budget with
// one score multiply, the threshold and budget check, then four letterbox
// multiplies on one shared multiplier and the result push, which waits while
// the result queue is full. A budget error skips the letterbox multiplies, a
// row below the threshold ends after the check, and a row skipped after a
// budget error or a bare frame mark is only popped. Short rows can raise full
// once the row queue is taken up. Configuration is written through the cfg
// port, which is always ready; the user must write it only while no row is in
// flight, as the block itself does not enforce it.
module detection_row_decoder_core #(
  parameter int MAX_CLASSES = drd_pkg::DEF_MAX_CLASSES
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [drd_pkg::VALUE_W-1:0]  value,
  input  wire logic                                end_of_row,
  input  wire logic                                end_of_frame,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic                                     status,
  output logic [drd_pkg::EDGE_W-1:0]               box_x,
  output logic [drd_pkg::EDGE_W-1:0]               box_y,
  output logic [drd_pkg::EDGE_W-1:0]               box_width,
  output logic [drd_pkg::EDGE_W-1:0]               box_height,
  output logic [drd_pkg::CLASS_W-1:0]              class_num,
  output logic [drd_pkg::CONF_W-1:0]               confidence,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [drd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [drd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import drd_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    job_push;
  job_t    job_in;
  job_t    job_out;
  logic    job_full;
  logic    job_empty;
  logic    job_pop;
  logic    res_push;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.score_floor  <= RST_SCORE_FLOOR;
      cfg.obj_enable   <= RST_OBJ_ENABLE;
      cfg.box_budget   <= RST_BOX_BUDGET;
      cfg.inv_scale    <= RST_INV_SCALE;
      cfg.pad_x        <= RST_PAD;
      cfg.pad_y        <= RST_PAD;
      cfg.image_width  <= RST_IMAGE_SIZE;
      cfg.image_height <= RST_IMAGE_SIZE;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_SCORE_FLOOR:  cfg.score_floor  <= cfg_data[CONF_W-1:0];
        REG_OBJ_ENABLE:   cfg.obj_enable   <= cfg_data[0];
        REG_BOX_BUDGET:   cfg.box_budget   <= cfg_data[COUNT_W-1:0];
        REG_INV_SCALE:    cfg.inv_scale    <= cfg_data[SCALE_W-1:0];
        REG_PAD_X:        cfg.pad_x        <= cfg_data[PAD_W-1:0];
        REG_PAD_Y:        cfg.pad_y        <= cfg_data[PAD_W-1:0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input word handshake
  assign full   = job_full;
  assign accept = push && !job_full;

  drd_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .value        (value),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame),
    .job_push     (job_push),
    .job          (job_in)
  );

  drd_fifo #(
    .T     (job_t),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_job_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  drd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  drd_fifo #(
    .T     (result_t),
    .DEPTH (RESULT_QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  // result word on the ports
  assign status     = res_out.status;
  assign box_x      = res_out.box_x;
  assign box_y      = res_out.box_y;
  assign box_width  = res_out.box_width;
  assign box_height = res_out.box_height;
  assign class_num  = res_out.class_num;
  assign confidence = res_out.confidence;

endmodule

`default_nettype wire

[rtl/core/drd_fifo.sv]
`default_nettype none

module drd_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire T     wdata,
  output logic      full,
  input  wire logic pop,
  output T          rdata,
  output logic      empty
);

  localparam int PTR_W = $clog2(DEPTH);

  T                 mem [DEPTH];
  logic [PTR_W:0]   wr_ptr;
  logic [PTR_W:0]   rd_ptr;

  // occupancy flags from the wrap bit
  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[PTR_W] != rd_ptr[PTR_W]) &&
                 (wr_ptr[PTR_W-1:0] == rd_ptr[PTR_W-1:0]);
  assign rdata = mem[rd_ptr[PTR_W-1:0]];

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[PTR_W-1:0]] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/core/drd_front.sv]
`default_nettype none

module drd_front #(
  parameter int MAX_CLASSES = drd_pkg::DEF_MAX_CLASSES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic signed [drd_pkg::VALUE_W-1:0] value,
  input  wire logic                         end_of_row,
  input  wire logic                         end_of_frame,
  output logic                              job_push,
  output drd_pkg::job_t                     job
);

  import drd_pkg::*;

  localparam int POS_LIMIT = ROW_HEAD + MAX_CLASSES;
  localparam int POS_W     = $clog2(POS_LIMIT + 1);
  localparam int CIDX_W    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] box [BOX_FIELDS];
  logic signed [VALUE_W-1:0] objectness;
  logic signed [VALUE_W-1:0] best_score;
  logic [CIDX_W-1:0]         top_class;

  logic                      class_slot;
  logic [CIDX_W-1:0]         class_index;
  logic                      take;
  logic signed [VALUE_W-1:0] best_score_now;
  logic [CIDX_W-1:0]         top_class_now;
  logic                      eval;
  logic                      row_done;

  // running argmax, first maximum wins
  always_comb begin
    class_slot     = (position >= POS_W'(ROW_HEAD)) && (position < POS_W'(POS_LIMIT));
    class_index    = CIDX_W'(position - POS_W'(ROW_HEAD));
    take           = class_slot && ((class_index == '0) || (value > best_score));
    best_score_now = take ? value : best_score;
    top_class_now  = take ? class_index : top_class;
    eval           = end_of_row && (position >= POS_W'(ROW_HEAD));
    row_done       = end_of_row || end_of_frame;
  end

  // row summary to the back end
  always_comb begin
    job_push        = accept && (eval || end_of_frame);
    job.eval        = eval;
    job.eof         = end_of_frame;
    job.cx          = box[0];
    job.cy          = box[1];
    job.w           = box[2];
    job.h           = box[3];
    job.objectness  = objectness;
    job.best_score  = best_score_now;
    job.top_class   = CLASS_W'(top_class_now);
  end

  // row position and argmax state
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      objectness <= '0;
      best_score <= '0;
      top_class  <= '0;
    end else if (accept) begin
      if (row_done) begin
        position   <= '0;
        objectness <= '0;
        best_score <= '0;
        top_class  <= '0;
      end else begin
        if (position == POS_W'(BOX_FIELDS)) begin
          objectness <= value;
        end
        best_score <= best_score_now;
        top_class  <= top_class_now;
        if (position < POS_W'(POS_LIMIT)) begin
          position <= position + 1'b1;
        end
      end
    end
  end

  // box fields, written before they are read
  always_ff @(posedge clk) begin
    if (accept && (position < POS_W'(BOX_FIELDS))) begin
      box[position[1:0]] <= value;
    end
  end

endmodule

`default_nettype wire

[rtl/core/drd_back.sv]
`default_nettype none

module drd_back (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire drd_pkg::cfg_t cfg,
  input  wire logic    job_empty,
  input  wire drd_pkg::job_t job,
  output logic         job_pop,
  input  wire logic    res_full,
  output logic         res_push,
  output drd_pkg::result_t res
);

  import drd_pkg::*;

  localparam int DIFF_W = 36;
  localparam int OPND_W = 33;
  localparam int PROD_W = 64;

  back_state_t               state;
  back_state_t               state_next;
  job_t                      jreg;
  logic signed [PROD_W-1:0]  prod;
  logic [CONF_W-1:0]         conf;
  logic                      err;
  logic [OPND_W-1:0]         d_op [BOX_FIELDS];
  logic [2:0]                cnt;
  logic [PROD_W-1:0]         mprod;
  logic [EDGE_W-1:0]         edge_pos [BOX_FIELDS];
  logic [COUNT_W-1:0]        kept_count;
  logic [COUNT_W-1:0]        kept_count_next;
  logic                      frame_failed;
  logic                      frame_failed_next;

  logic signed [47:0]        score;
  logic                      pass;
  logic                      over_budget;
  logic [CONF_W-1:0]         conf_sat;
  logic signed [DIFF_W-1:0]  x_lo, x_hi, y_lo, y_hi;
  logic [1:0]                prev_idx;
  logic [EDGE_W-1:0]         bound;
  logic [PROD_W-18:0]        scaled;
  logic [EDGE_W-1:0]         clamped;
  logic [EDGE_W-1:0]         bw;
  logic [EDGE_W-1:0]         bh;
  logic                      keep;

  // only a positive distance from the pad reaches the multiplier
  function automatic logic [OPND_W-1:0] mul_operand(input logic signed [DIFF_W-1:0] d);
    mul_operand = (d > 0) ? d[OPND_W-1:0] : '0;
  endfunction

  // corners in Q.17 relative to twice the pad, ordered by the sign of the size
  function automatic logic signed [DIFF_W-1:0] corner(
    input logic signed [VALUE_W-1:0] c,
    input logic signed [VALUE_W-1:0] s,
    input logic [PAD_W-1:0]          pad,
    input logic                      upper
  );
    logic signed [DIFF_W-1:0] c2;
    logic signed [DIFF_W-1:0] sx;
    logic signed [DIFF_W-1:0] p2;
    c2 = {{3{c[VALUE_W-1]}}, c, 1'b0};
    sx = {{4{s[VALUE_W-1]}}, s};
    p2 = {8'd0, pad, 1'b0};
    if (upper ^ s[VALUE_W-1]) begin
      corner = c2 + sx - p2;
    end else begin
      corner = c2 - sx - p2;
    end
  endfunction

  // score, threshold and budget
  always_comb begin
    if (cfg.obj_enable) begin
      score = $signed(prod[PROD_W-1:16]);
    end else begin
      score = {{16{jreg.best_score[VALUE_W-1]}}, jreg.best_score};
    end
    pass        = score >= $signed({31'd0, cfg.score_floor});
    over_budget = kept_count >= cfg.box_budget;
    conf_sat    = (score > $signed({31'd0, CONF_MAX})) ? CONF_MAX : score[CONF_W-1:0];
    x_lo        = corner(jreg.cx, jreg.w, cfg.pad_x, 1'b0);
    x_hi        = corner(jreg.cx, jreg.w, cfg.pad_x, 1'b1);
    y_lo        = corner(jreg.cy, jreg.h, cfg.pad_y, 1'b0);
    y_hi        = corner(jreg.cy, jreg.h, cfg.pad_y, 1'b1);
  end

  // clamp of the previous product to the image
  always_comb begin
    prev_idx = 2'(cnt - 3'd1);
    if (prev_idx[1]) begin
      bound = {cfg.image_height, 16'd0};
    end else begin
      bound = {cfg.image_width, 16'd0};
    end
    scaled  = mprod[PROD_W-1:17];
    clamped = ({17'd0, bound} < scaled) ? bound : scaled[EDGE_W-1:0];
    bw      = edge_pos[1] - edge_pos[0];
    bh      = edge_pos[3] - edge_pos[2];
    keep    = (bw != '0) && (bh != '0);
  end

  // result word
  always_comb begin
    if (err) begin
      res.status     = STATUS_BUDGET;
      res.box_x      = '0;
      res.box_y      = '0;
      res.box_width  = '0;
      res.box_height = '0;
      res.class_num  = '0;
      res.confidence = '0;
    end else begin
      res.status     = STATUS_KEPT;
      res.box_x      = edge_pos[0];
      res.box_y      = edge_pos[2];
      res.box_width  = bw;
      res.box_height = bh;
      res.class_num  = jreg.top_class;
      res.confidence = conf;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      kept_count   <= '0;
      frame_failed <= 1'b0;
    end else begin
      state        <= state_next;
      kept_count   <= kept_count_next;
      frame_failed <= frame_failed_next;
    end
  end

  // next state, frame counters and handshakes
  always_comb begin
    state_next        = state;
    job_pop           = 1'b0;
    res_push          = 1'b0;
    kept_count_next   = kept_count;
    frame_failed_next = frame_failed;
    unique case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          if (job.eval && !frame_failed) begin
            state_next = BK_SCORE;
          end else if (job.eof) begin
            kept_count_next   = '0;
            frame_failed_next = 1'b0;
          end
        end
      end
      BK_SCORE: begin
        state_next = BK_CHECK;
      end
      BK_CHECK: begin
        if (!pass) begin
          state_next = BK_IDLE;
          if (jreg.eof) begin
            kept_count_next   = '0;
            frame_failed_next = 1'b0;
          end
        end else if (over_budget) begin
          state_next = BK_EMIT;
        end else begin
          state_next = BK_MAP;
        end
      end
      BK_MAP: begin
        if (cnt == 3'd4) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (err || keep) begin
          if (!res_full) begin
            res_push   = 1'b1;
            state_next = BK_IDLE;
            if (jreg.eof) begin
              kept_count_next   = '0;
              frame_failed_next = 1'b0;
            end else if (err) begin
              frame_failed_next = 1'b1;
            end else begin
              kept_count_next = COUNT_W'(kept_count + 1'b1);
            end
          end
        end else begin
          state_next = BK_IDLE;
          if (jreg.eof) begin
            kept_count_next   = '0;
            frame_failed_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (job_pop) begin
          jreg <= job;
        end
      end
      BK_SCORE: begin
        prod <= PROD_W'($signed(jreg.objectness)) * PROD_W'($signed(jreg.best_score));
      end
      BK_CHECK: begin
        err     <= over_budget;
        conf    <= conf_sat;
        d_op[0] <= mul_operand(x_lo);
        d_op[1] <= mul_operand(x_hi);
        d_op[2] <= mul_operand(y_lo);
        d_op[3] <= mul_operand(y_hi);
        cnt     <= '0;
      end
      BK_MAP: begin
        cnt <= cnt + 1'b1;
        if (cnt != 3'd4) begin
          mprod <= {31'd0, d_op[cnt[1:0]]} * {33'd0, cfg.inv_scale};
        end
        if (cnt != 3'd0) begin
          edge_pos[prev_idx] <= clamped;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/drd_checker.sv]
`default_nettype none

module drd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        status,
  input wire logic [29:0] box_x,
  input wire logic [29:0] box_y,
  input wire logic [29:0] box_width,
  input wire logic [29:0] box_height,
  input wire logic [6:0]  class_num,
  input wire logic [16:0] confidence
);

  // result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a budget error word carries no box
  a_error_clear: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (box_x == 30'd0 && box_y == 30'd0 && box_width == 30'd0 &&
                            box_height == 30'd0 && class_num == 7'd0 &&
                            confidence == 17'd0))
    else $error("budget error word with nonzero fields");

  // a kept box always has area and a confidence no greater than the saturation point
  a_kept_box: assert property (@(posedge clk) disable iff (rst)
    (!empty && !status) |-> (box_width != 30'd0 && box_height != 30'd0 &&
                             confidence <= 17'd65536))
    else $error("kept box with no area or confidence out of range");

  // a waiting word holds until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(box_x) && $stable(status) &&
                          $stable(confidence)))
    else $error("waiting result changed before pop");

endmodule

bind detection_row_decoder_core drd_checker u_drd_checker (.*);

`default_nettype wire
